@@ rtl/utf8_byte_stream_decoder_assert.svh @@
// Assertion macros shared by the UTF-8 byte stream decoder.
`ifndef UTF8_BYTE_STREAM_DECODER_ASSERT_SVH
`define UTF8_BYTE_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define UBSD_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ubsd assertion failed");

// Next-cycle implication, checked outside reset.
`define UBSD_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ubsd assertion failed");

`endif

@@ rtl/ubsd_pkg.sv @@
// Package with types and constants for the UTF-8 byte stream decoder.
package ubsd_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CP_W   = 21;

   // Lead and continuation byte patterns.
   localparam logic [7:0] ASCII_MAX  = 8'h7F;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_PAT  = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_PAT  = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_PAT  = 8'hF0;
   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_PAT   = 8'h80;

   // Continuation counts set by a lead byte.
   localparam logic [1:0] PEND_NONE = 2'd0;
   localparam logic [1:0] PEND_ONE  = 2'd1;
   localparam logic [1:0] PEND_TWO  = 2'd2;
   localparam logic [1:0] PEND_THREE = 2'd3;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              last_byte;
   } req_type;

   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            point_valid;
      logic            end_of_text;
   } rsp_type;

   typedef struct packed {
      logic [1:0]      bytes_pending;
      logic [CP_W-1:0] partial_value;
      logic            sequence_broken;
   } dec_state_type;

endpackage

@@ rtl/utf8_byte_stream_decoder.sv @@
// A request passes through the input register, the decode step and the result register; one result per request.
// Throughput: one request per cycle; the input and result registers both refill
// in the cycle they drain, so a stall on the result side is the only limit.
// Reset: synchronous, active high; clears both stage valid bits and the
// pending count, partial value and broken flag of the running sequence.
`include "utf8_byte_stream_decoder_assert.svh"
module utf8_byte_stream_decoder
   import ubsd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic          in_valid;
   logic          in_stall;
   req_type       in_data;
   rsp_type       rsp_next;
   dec_state_type dec_state;
   logic          advance;

   // Input register.
   ubsd_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .in_valid  (in_valid),
      .in_stall  (in_stall),
      .in_data   (in_data)
   );

   // The decoder steps once per request moved into the result register.
   assign advance = in_valid && !in_stall;

   ubsd_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_data   (in_data),
      .rsp_next  (rsp_next),
      .dec_state (dec_state)
   );

   // Result register.
   ubsd_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .in_stall  (in_stall),
      .rsp_next  (rsp_next),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // A delivered code point is never zero, and an empty result carries zero.
   `UBSD_ASSERT_NOW(a_point_nonzero, clock, reset,
      rsp_valid && rsp_data.point_valid, rsp_data.code_point != '0)
   `UBSD_ASSERT_NOW(a_empty_is_zero, clock, reset,
      rsp_valid && !rsp_data.point_valid, rsp_data.code_point == '0)
   // The final byte of a text leaves no sequence behind.
   `UBSD_ASSERT_NEXT(a_end_clears, clock, reset,
      advance && in_data.last_byte,
      dec_state.bytes_pending == PEND_NONE && !dec_state.sequence_broken)

endmodule

@@ rtl/ubsd_in_stage.sv @@
// Input register stage: holds one accepted request until the decoder takes it.
module ubsd_in_stage
   import ubsd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    in_valid,
   input  logic    in_stall,
   output req_type in_data
);

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;
   logic    req_take;

   // The register refills in the same cycle it empties.
   assign req_stall = valid_ff && in_stall;
   assign req_take  = req_valid && !req_stall;
   assign valid_in  = req_take || (valid_ff && in_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         data_ff <= req_data;
      end
   end

   assign in_valid = valid_ff;
   assign in_data  = data_ff;

endmodule

@@ rtl/ubsd_decode.sv @@
// Decoder core: running sequence state and the per-byte decode step.
module ubsd_decode
   import ubsd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  req_type       in_data,
   output rsp_type       rsp_next,
   output dec_state_type dec_state
);

   dec_state_type state_ff;
   dec_state_type state_in;
   logic [BYTE_W-1:0] b;
   logic [CP_W-1:0]   cp;
   logic              cp_valid;

   assign b = in_data.data_byte;

   // One decode step on the held byte.
   always_comb begin
      state_in = state_ff;
      cp       = '0;
      cp_valid = 1'b0;
      if (state_ff.bytes_pending == PEND_NONE) begin
         priority if (b <= ASCII_MAX) begin
            cp       = {{(CP_W-BYTE_W){1'b0}}, b};
            cp_valid = (b != '0);
         end else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
            state_in.partial_value   = {{(CP_W-5){1'b0}}, b[4:0]};
            state_in.bytes_pending   = PEND_ONE;
            state_in.sequence_broken = 1'b0;
         end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
            state_in.partial_value   = {{(CP_W-4){1'b0}}, b[3:0]};
            state_in.bytes_pending   = PEND_TWO;
            state_in.sequence_broken = 1'b0;
         end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
            state_in.partial_value   = {{(CP_W-3){1'b0}}, b[2:0]};
            state_in.bytes_pending   = PEND_THREE;
            state_in.sequence_broken = 1'b0;
         end else begin
            // Stray continuation or invalid lead byte is skipped.
            state_in = state_ff;
         end
      end else begin
         // A slot byte: collect six bits or void the sequence.
         if (!state_ff.sequence_broken) begin
            if ((b & CONT_MASK) != CONT_PAT) begin
               state_in.sequence_broken = 1'b1;
               state_in.partial_value   = '0;
            end else begin
               state_in.partial_value = {state_ff.partial_value[CP_W-7:0], b[5:0]};
            end
         end
         state_in.bytes_pending = state_ff.bytes_pending - 2'd1;
         if (state_in.bytes_pending == PEND_NONE) begin
            if (!state_in.sequence_broken && (state_in.partial_value != '0)) begin
               cp       = state_in.partial_value;
               cp_valid = 1'b1;
            end
            state_in.partial_value   = '0;
            state_in.sequence_broken = 1'b0;
         end
      end
      // The final byte of a text drops any unfinished sequence.
      if (in_data.last_byte) begin
         state_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   assign rsp_next.code_point  = cp;
   assign rsp_next.point_valid = cp_valid;
   assign rsp_next.end_of_text = in_data.last_byte;
   assign dec_state            = state_ff;

endmodule

@@ rtl/ubsd_out_stage.sv @@
// Result register stage: holds a decoded result until the consumer takes it.
module ubsd_out_stage
   import ubsd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_stall,
   input  rsp_type rsp_next,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;
   logic    load;

   // A new result loads when the register is empty or being drained.
   assign in_stall = valid_ff && rsp_stall;
   assign load     = in_valid && !in_stall;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= rsp_next;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
